@@ rtl/hms_pkg.sv @@
// Shared constants and types for the map pixel shader.
package hms_pkg;

  localparam int HEIGHT_WIDTH_DEF = 24;

  localparam int Q_ONE          = 65536;
  localparam int K_LIGHT_XY     = 32766;
  localparam int K_LIGHT_Z      = 46344;
  localparam int K_SEVEN_TENTHS = 45875;
  localparam int K_SHADE_LOW    = 36045;
  localparam int K_ELEV_LOW     = 49152;
  localparam int MIN_SPAN       = 16;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_WATER_EN  = 3'd0;
  localparam logic [2:0] REG_WATER_LVL = 3'd1;
  localparam logic [2:0] REG_TERR_MIN  = 3'd2;
  localparam logic [2:0] REG_TERR_MAX  = 3'd3;
  localparam logic [2:0] REG_VOXEL     = 3'd4;

  // Register reset values.
  localparam logic [23:0] RST_WATER_LVL = 24'd0;
  localparam logic [23:0] RST_TERR_MIN  = 24'hFFC000;
  localparam logic [23:0] RST_TERR_MAX  = 24'd16384;
  localparam logic [15:0] RST_VOXEL     = 16'd1600;

  // Normal inputs of the hillshade unit.
  typedef struct packed {
    logic signed [33:0] a;
    logic signed [33:0] b;
    logic [17:0]        d;
  } hms_norm_t;

endpackage

@@ rtl/hillshade_map_pixel_shader.sv @@
// Top level of the map pixel shader: config registers and shading pipeline.
//
// Usage: drive one pixel beat on height_* and base_* with start high; busy is
// always low, so a beat can be accepted every cycle. Each pixel produces one
// result beat on out_red/out_green/out_blue/is_water marked by done, held for
// exactly one cycle; the receiver cannot stall and results come in order.
// At every width the hillshade path sets when done rises: four stages of
// pre-scaling, squares and normalizing, a 32-step square root over 32 stages
// and the 17-stage shading divider, then three stages of factors and output.
// The span divider path is delayed to line up with it.
// Throughput is one pixel per clock.
// Configuration is an APB port; registers sit at byte addresses 4*i. The user
// must write them only while no pixel is in flight; the block does not enforce
// this. Reset clears all valid bits and loads the register reset values; no
// result comes out after reset until a pixel is started.
module hillshade_map_pixel_shader #(
  parameter int HEIGHT_WIDTH = hms_pkg::HEIGHT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [HEIGHT_WIDTH-1:0] height_center,
  input  logic signed [HEIGHT_WIDTH-1:0] height_left,
  input  logic signed [HEIGHT_WIDTH-1:0] height_right,
  input  logic signed [HEIGHT_WIDTH-1:0] height_down,
  input  logic signed [HEIGHT_WIDTH-1:0] height_up,
  input  logic [7:0]                     base_red,
  input  logic [7:0]                     base_green,
  input  logic [7:0]                     base_blue,
  output logic                           done,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           is_water,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int HW  = HEIGHT_WIDTH;
  localparam int SW  = HW + 2;       // spans and differences
  localparam int NW  = SW + 16;      // span numerator
  localparam int AW  = HW + 2;       // central differences
  localparam int SQW = 31;           // root width (S < 2^62)
  localparam int FW  = 32;           // shading numerator width (< 2^48 >> 16 fits)
  localparam int SLAT = SQW;         // sqrt stages
  localparam int TLW = 1 + 24 + 1;   // tag: water, color, ratio-zero

  //--------------------------------------------------------------------------
  // Configuration registers
  //--------------------------------------------------------------------------
  logic        water_enabled;
  logic [23:0] water_level;
  logic [23:0] terrain_min;
  logic [23:0] terrain_max;
  logic [15:0] voxel_size;
  logic        wr;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  // Write one register per completed write beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      water_enabled <= 1'b0;
      water_level   <= hms_pkg::RST_WATER_LVL;
      terrain_min   <= hms_pkg::RST_TERR_MIN;
      terrain_max   <= hms_pkg::RST_TERR_MAX;
      voxel_size    <= hms_pkg::RST_VOXEL;
    end else if (wr) begin
      case (ridx)
        hms_pkg::REG_WATER_EN:  water_enabled <= pwdata[0];
        hms_pkg::REG_WATER_LVL: water_level   <= pwdata[23:0];
        hms_pkg::REG_TERR_MIN:  terrain_min   <= pwdata[23:0];
        hms_pkg::REG_TERR_MAX:  terrain_max   <= pwdata[23:0];
        hms_pkg::REG_VOXEL:     voxel_size    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    case (ridx)
      hms_pkg::REG_WATER_EN:  prdata = {31'd0, water_enabled};
      hms_pkg::REG_WATER_LVL: prdata = {8'd0, water_level};
      hms_pkg::REG_TERR_MIN:  prdata = {8'd0, terrain_min};
      hms_pkg::REG_TERR_MAX:  prdata = {8'd0, terrain_max};
      hms_pkg::REG_VOXEL:     prdata = {16'd0, voxel_size};
      default:                prdata = '0;
    endcase
  end

  // Level registers read as HEIGHT_WIDTH-bit signed values.
  logic signed [HW-1:0] wl;
  logic signed [HW-1:0] tmin;
  logic signed [HW-1:0] tmax;
  always_comb begin
    logic [HW+23:0] x;
    x = {{HW{1'b0}}, water_level};  wl   = HW'(x);
    x = {{HW{1'b0}}, terrain_min};  tmin = HW'(x);
    x = {{HW{1'b0}}, terrain_max};  tmax = HW'(x);
  end

  //--------------------------------------------------------------------------
  // Stage 1: differences, spans, water decision
  //--------------------------------------------------------------------------
  logic                 s1_v;
  logic                 s1_wat;
  logic [SW-1:0]        s1_num;   // non-negative ratio numerator
  logic [SW-1:0]        s1_den;
  logic                 s1_zero;  // ratio forced to zero
  logic signed [AW-1:0] s1_a;
  logic signed [AW-1:0] s1_b;
  logic [17:0]          s1_d;
  logic [23:0]          s1_col;

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] lspan;
    logic signed [SW-1:0] dspan;
    logic signed [SW-1:0] num;
    logic                 wat;
    base  = water_enabled ? SW'(wl) : SW'(tmin);
    lspan = SW'(tmax) - base;
    dspan = base - SW'(tmin);
    if (lspan < SW'(hms_pkg::MIN_SPAN)) lspan = SW'(hms_pkg::MIN_SPAN);
    if (dspan < SW'(hms_pkg::MIN_SPAN)) dspan = SW'(hms_pkg::MIN_SPAN);
    wat = water_enabled && (height_center < wl);
    num = wat ? (SW'(wl) - SW'(height_center)) : (SW'(height_center) - base);
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    s1_wat  <= wat;
    s1_zero <= (num <= 0);
    s1_num  <= (num <= 0) ? '0 : num;
    s1_den  <= wat ? dspan : lspan;
    s1_a    <= AW'(height_right) - AW'(height_left);
    s1_b    <= AW'(height_up) - AW'(height_down);
    s1_d    <= (voxel_size == 16'd0) ? 18'd2 : {1'b0, voxel_size, 1'b0};
    s1_col  <= {base_red, base_green, base_blue};
  end

  //--------------------------------------------------------------------------
  // Stage 2: clamp the ratio numerator so the quotient fits 17 bits
  //--------------------------------------------------------------------------
  logic          s2_v;
  logic [NW-1:0] s2_num;
  logic [SW-1:0] s2_den;
  logic [TLW-1:0] s2_tag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    // A ratio above one saturates; feed exactly den << 16 in that case.
    if (s1_num > s1_den) begin
      s2_num <= {s1_den, 16'd0};
    end else begin
      s2_num <= {s1_num, 16'd0};
    end
    s2_den <= s1_den;
    s2_tag <= {s1_wat, s1_col, s1_zero};
  end

  //--------------------------------------------------------------------------
  // Span ratio divider
  //--------------------------------------------------------------------------
  logic           rd_v;
  logic [16:0]    rd_q;
  logic [TLW-1:0] rd_tag;
  hms_div #(.NW(NW), .DW(SW), .QW(17), .TW(TLW)) u_ratio (
    .clk(clk), .rst(rst), .in_valid(s2_v), .num(s2_num), .den(s2_den), .tag(s2_tag),
    .out_valid(rd_v), .quot(rd_q), .out_tag(rd_tag)
  );

  //--------------------------------------------------------------------------
  // Hillshade path: pre-scale, light dot product, square sum
  //--------------------------------------------------------------------------
  logic signed [29:0] h1_a, h1_b;
  logic [28:0]        h1_d;
  // Halve until all magnitudes fall below 2^28 (bounded count, parallel form).
  // Shift the magnitudes so each halving truncates toward zero.
  always_ff @(posedge clk) begin
    logic [AW-1:0] ma, mb, mx;
    int            k;
    ma = s1_a[AW-1] ? AW'(-s1_a) : AW'(s1_a);
    mb = s1_b[AW-1] ? AW'(-s1_b) : AW'(s1_b);
    mx = ma | mb | AW'(s1_d);
    k = 0;
    for (int j = 28; j < AW; j++) begin
      if (mx[j]) k = j - 27;
    end
    h1_a <= s1_a[AW-1] ? 30'(-(ma >> k)) : 30'(ma >> k);
    h1_b <= s1_b[AW-1] ? 30'(-(mb >> k)) : 30'(mb >> k);
    h1_d <= 29'(s1_d >> k);
  end

  // Dot product with the light and squares.
  logic signed [47:0] h2_n;
  logic [57:0]        h2_aa, h2_bb, h2_dd;
  always_ff @(posedge clk) begin
    logic signed [30:0] ab;
    ab    = 31'(h1_a) + 31'(h1_b);
    h2_n  <= 48'(ab) * 48'(hms_pkg::K_LIGHT_XY) +
             48'($signed({1'b0, h1_d})) * 48'(hms_pkg::K_LIGHT_Z);
    h2_aa <= 58'(h1_a * h1_a);
    h2_bb <= 58'(h1_b * h1_b);
    h2_dd <= 58'(h1_d * h1_d);
  end

  // Sum of squares.
  logic signed [47:0] h3_n;
  logic [59:0]        h3_s;
  always_ff @(posedge clk) begin
    h3_n <= h2_n;
    h3_s <= 60'(h2_aa) + 60'(h2_bb) + 60'(h2_dd);
  end

  // Normalize S to at least 2^60 by even shifts.
  logic signed [47:0] h4_n;
  logic [63:0]        h4_s;
  logic [4:0]         h4_sh;
  always_ff @(posedge clk) begin
    logic [4:0] s;
    s = 5'd0;
    for (int j = 0; j < 30; j++) begin
      if (h3_s[2*j+1 -: 2] != 2'd0) s = 5'(30 - j);
    end
    if (h3_s == 60'd0) s = 5'd0;
    h4_n  <= h3_n;
    h4_sh <= s;
    h4_s  <= 64'(h3_s) << (2 * s);
  end

  //--------------------------------------------------------------------------
  // Bit-serial square root, one result bit per stage
  //--------------------------------------------------------------------------
  logic [63:0]        sq_x  [SLAT+1];
  logic [63:0]        sq_r  [SLAT+1];
  logic signed [47:0] sq_n  [SLAT+1];
  logic [4:0]         sq_sh [SLAT+1];
  assign sq_x[0]  = h4_s;
  assign sq_r[0]  = '0;
  assign sq_n[0]  = h4_n;
  assign sq_sh[0] = h4_sh;
  for (genvar i = 0; i < SLAT; i++) begin : g_sqrt
    localparam int P = 2 * (SLAT - 1 - i) + 2;
    always_ff @(posedge clk) begin
      logic [63:0] bitv;
      logic [63:0] t;
      bitv = 64'd1 << P;
      t    = sq_r[i] + bitv;
      if (sq_x[i] >= t) begin
        sq_x[i+1] <= sq_x[i] - t;
        sq_r[i+1] <= (sq_r[i] >> 1) + bitv;
      end else begin
        sq_x[i+1] <= sq_x[i];
        sq_r[i+1] <= sq_r[i] >> 1;
      end
      sq_n[i+1]  <= sq_n[i];
      sq_sh[i+1] <= sq_sh[i];
    end
  end

  // Last root step (bit 1) and numerator shift.
  logic [31:0]        h5_r;
  logic [FW+15:0]     h5_num;
  logic               h5_pos;
  always_ff @(posedge clk) begin
    logic [63:0] t;
    logic [31:0] r;
    logic [79:0] nsh;
    t = sq_r[SLAT] + 64'd1;
    r = (sq_x[SLAT] >= t) ? 32'((sq_r[SLAT] >> 1) + 64'd1) : 32'(sq_r[SLAT] >> 1);
    nsh = 80'(sq_n[SLAT]) << sq_sh[SLAT];
    h5_pos <= (sq_n[SLAT] > 0) && (r != 32'd0);
    h5_r   <= r;
    // Saturate when the quotient would exceed one.
    if (nsh > ({48'd0, r} << 16)) begin
      h5_num <= 48'({r, 16'd0});
    end else begin
      h5_num <= 48'(nsh);
    end
  end

  logic        sd_v;
  logic [16:0] sd_q;
  logic        sd_pos;
  hms_div #(.NW(FW+16), .DW(32), .QW(17), .TW(1)) u_shade (
    .clk(clk), .rst(rst), .in_valid(1'b1), .num(h5_num),
    .den((h5_r == 32'd0) ? 32'd1 : h5_r), .tag(h5_pos),
    .out_valid(sd_v), .quot(sd_q), .out_tag(sd_pos)
  );

  //--------------------------------------------------------------------------
  // Align the ratio path with the shading path
  //--------------------------------------------------------------------------
  localparam int RLAT = 1 + 17;                  // stage 2 + ratio divider
  localparam int HLAT = 4 + SLAT + 1 + 17;       // hillshade stages
  localparam int DLY  = HLAT - RLAT;

  logic           al_v   [DLY+1];
  logic [16:0]    al_q   [DLY+1];
  logic [TLW-1:0] al_tag [DLY+1];
  assign al_v[0]   = rd_v;
  assign al_q[0]   = rd_q;
  assign al_tag[0] = rd_tag;
  for (genvar i = 0; i < DLY; i++) begin : g_align
    always_ff @(posedge clk) begin
      if (rst) begin
        al_v[i+1] <= 1'b0;
      end else begin
        al_v[i+1] <= al_v[i];
      end
      al_q[i+1]   <= al_q[i];
      al_tag[i+1] <= al_tag[i];
    end
  end

  //--------------------------------------------------------------------------
  // Factors: water depth factor or elevation times shade
  //--------------------------------------------------------------------------
  logic        f1_v;
  logic        f1_wat;
  logic [23:0] f1_col;
  logic [16:0] f1_wf;
  logic [16:0] f1_elev;
  logic [16:0] f1_shade;
  always_ff @(posedge clk) begin
    logic [16:0] e;
    logic [16:0] nd;
    logic [33:0] p1, p2;
    e  = al_tag[DLY][0] ? 17'd0 : al_q[DLY];
    nd = sd_pos ? sd_q : 17'd0;
    p1 = 34'(e) * 34'(hms_pkg::K_SEVEN_TENTHS);
    p2 = 34'(nd) * 34'(hms_pkg::K_SEVEN_TENTHS);
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= al_v[DLY];
    end
    f1_wat   <= al_tag[DLY][TLW-1];
    f1_col   <= al_tag[DLY][24:1];
    f1_wf    <= 17'(hms_pkg::Q_ONE) - 17'(p1 >> 16);
    f1_elev  <= 17'(hms_pkg::K_ELEV_LOW) + 17'(e >> 2);
    f1_shade <= 17'(hms_pkg::K_SHADE_LOW) + 17'(p2 >> 16);
  end

  logic        f2_v;
  logic        f2_wat;
  logic [23:0] f2_col;
  logic [16:0] f2_wf;
  logic [16:0] f2_bright;
  always_ff @(posedge clk) begin
    logic [33:0] p;
    p = 34'(f1_elev) * 34'(f1_shade);
    if (rst) begin
      f2_v <= 1'b0;
    end else begin
      f2_v <= f1_v;
    end
    f2_wat    <= f1_wat;
    f2_col    <= f1_col;
    f2_wf     <= f1_wf;
    f2_bright <= 17'(p >> 16);
  end

  // Scale channels, saturate, register the result beat.
  function automatic logic [7:0] chan(input logic [7:0] c, input logic [16:0] f);
    logic [24:0] p;
    logic [8:0]  s;
    p = 25'(c) * 25'(f);
    s = 9'(p >> 16);
    return (s > 9'd255) ? 8'd255 : s[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f2_v;
    end
    is_water <= f2_wat;
    if (f2_wat) begin
      out_red   <= chan(8'd20, f2_wf);
      out_green <= chan(8'd80, f2_wf);
      out_blue  <= chan(8'd180, f2_wf);
    end else begin
      out_red   <= chan(f2_col[23:16], f2_bright);
      out_green <= chan(f2_col[15:8], f2_bright);
      out_blue  <= chan(f2_col[7:0], f2_bright);
    end
  end

`ifndef NO_ASSERTIONS
  // A water beat never carries a shade above the clear-water blue.
  a_water_blue: assert property (@(posedge clk) disable iff (rst)
    done && is_water |-> out_blue <= 8'd180) else $error("water blue too bright");
  // The shading divider result for a pixel in flight is never above one.
  a_shade_sat: assert property (@(posedge clk) disable iff (rst)
    sd_v && al_v[DLY] |-> sd_q <= 17'd65536) else $error("shade ratio above one");
  // No result beat appears without a pixel in flight.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(f2_v)) else $error("spurious result");
`endif

endmodule

@@ rtl/hms_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
module hms_div #(
  parameter int NW = 32,
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [TW-1:0] out_tag
);

  // Quotient = num / den, known to fit in QW bits (num < den << QW).
  localparam int RW = DW + 1;

  logic [QW:0]         v;
  logic [RW-1:0]       rem  [QW+1];
  logic [NW-1:0]       nsh  [QW+1];
  logic [QW-1:0]       q    [QW+1];
  logic [DW-1:0]       dd   [QW+1];
  logic [TW-1:0]       tg   [QW+1];

  assign v[0]    = in_valid;
  assign nsh[0]  = num;
  assign rem[0]  = '0;
  assign q[0]    = '0;
  assign dd[0]   = den;
  assign tg[0]   = tag;

  // One bit per stage: by the bound the numerator bits above QW are below den,
  // so we seed the remainder with the high bits and shift in QW bits.
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic [RW-1:0] sub;
    logic [RW-1:0] seed;
    always_comb begin
      if (i == 0) begin
        seed = RW'(nsh[0] >> QW);
      end else begin
        seed = rem[i];
      end
      trial = {seed[RW-2:0], nsh[i][QW-1-i]};
      sub   = trial - {1'b0, dd[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      nsh[i+1] <= nsh[i];
      dd[i+1]  <= dd[i];
      tg[i+1]  <= tg[i];
      if (!sub[RW-1]) begin
        rem[i+1] <= sub;
        q[i+1]   <= {q[i][QW-2:0], 1'b1};
      end else begin
        rem[i+1] <= trial;
        q[i+1]   <= {q[i][QW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];
  assign out_tag   = tg[QW];

endmodule
